[rtl/dse_pkg.sv]
// ----------------------------------------------------------------------------
// dse_pkg
// Types, constants and arithmetic helpers of the detection stabilizer.
// ----------------------------------------------------------------------------
package dse_pkg;

  localparam int SCORE_BITS = 16;
  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 8;
  localparam int KIND_BITS  = 3;
  localparam int NEED_BITS  = 2;
  localparam int IDX_BITS   = 3;
  localparam int CFG_BITS   = SCORE_BITS + 1;

  localparam longint ONE_Q_INT = longint'(1) << SCORE_BITS;

  localparam logic [SCORE_BITS:0]   ONE_Q      = (SCORE_BITS+1)'(ONE_Q_INT);
  localparam logic [SCORE_BITS:0]   WEIGHT_MIN = (SCORE_BITS+1)'((ONE_Q_INT * 5 + 50) / 100);
  localparam logic [SCORE_BITS-1:0] FLOOR_MIN  = SCORE_BITS'((ONE_Q_INT * 5 + 50) / 100);
  localparam logic [SCORE_BITS-1:0] FLOOR_MAX  = SCORE_BITS'((ONE_Q_INT * 95 + 50) / 100);
  localparam logic [SCORE_BITS-1:0] DECAY_Q    = SCORE_BITS'((ONE_Q_INT * 85 + 50) / 100);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [NEED_BITS-1:0]  PENDING_MAX = {NEED_BITS{1'b1}};
  localparam logic [NEED_BITS-1:0]  NEED_MIN    = NEED_BITS'(2);
  localparam logic [COORD_BITS-1:0] COORD_SIGN  = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam logic [KIND_BITS-1:0] KIND_NONE  = KIND_BITS'(0);
  localparam logic [KIND_BITS-1:0] KIND_CROSS = KIND_BITS'(1);
  localparam logic [KIND_BITS-1:0] KIND_TEE   = KIND_BITS'(2);
  localparam logic [KIND_BITS-1:0] KIND_ELL   = KIND_BITS'(3);

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_FILTER_ON   = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_EMA_WEIGHT  = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] REG_HOLD_LIMIT  = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] REG_REACQUIRE   = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] REG_SCORE_FLOOR = IDX_BITS'(4);

  // stream packing
  localparam int IN_DATA_BITS  = 1 + SCORE_BITS + 2 * COORD_BITS;
  localparam int IN_TDATA_BITS = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 1 + SCORE_BITS + 2 * COORD_BITS + 2 + COUNT_BITS + 1;
  localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int TUSER_BITS    = ((KIND_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                  valid;
    logic [KIND_BITS-1:0]  kind;
    logic [SCORE_BITS-1:0] score;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic [KIND_BITS-1:0]  kind;
    logic [SCORE_BITS-1:0] score;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  stable;
    logic                  held;
    logic [COUNT_BITS-1:0] run_length;
    logic                  is_junction;
  } result_t;

  // clamped configuration as seen by the tracker
  typedef struct packed {
    logic                  filter_on;
    logic [SCORE_BITS:0]   weight;
    logic [COUNT_BITS-1:0] hold_limit;
    logic [NEED_BITS-1:0]  need;
    logic [SCORE_BITS-1:0] floor;
  } cfg_t;

  function automatic logic junction(input logic [KIND_BITS-1:0] kind);
    return (kind == KIND_CROSS) || (kind == KIND_TEE) || (kind == KIND_ELL);
  endfunction

  // old*(1-w) + neu*w rounded half up, written as old + round((neu-old)*w)
  function automatic logic [SCORE_BITS-1:0] blend(input logic [SCORE_BITS-1:0] old_v,
                                                  input logic [SCORE_BITS-1:0] neu_v,
                                                  input logic [SCORE_BITS:0]   w);
    logic signed [SCORE_BITS:0]       diff;
    logic signed [2*SCORE_BITS+2:0]   d_ext;
    logic signed [2*SCORE_BITS+2:0]   w_ext;
    logic signed [2*SCORE_BITS+2:0]   prod;
    logic signed [2*SCORE_BITS+2:0]   step;
    diff  = $signed({1'b0, neu_v}) - $signed({1'b0, old_v});
    d_ext = {{(SCORE_BITS+2){diff[SCORE_BITS]}}, diff};
    w_ext = {{(SCORE_BITS+2){1'b0}}, w};
    prod  = d_ext * w_ext;
    step  = (prod + $signed({{(SCORE_BITS+2){1'b0}}, ONE_Q >> 1})) >>> SCORE_BITS;
    return old_v + step[SCORE_BITS-1:0];
  endfunction

  function automatic logic [SCORE_BITS-1:0] decay(input logic [SCORE_BITS-1:0] s);
    logic [2*SCORE_BITS-1:0] prod;
    prod = {{SCORE_BITS{1'b0}}, s} * {{SCORE_BITS{1'b0}}, DECAY_Q};
    return prod[2*SCORE_BITS-1:SCORE_BITS];
  endfunction

endpackage

[rtl/dse_cfg.sv]
// ----------------------------------------------------------------------------
// dse_cfg
// Configuration registers with range clamping applied on the read side.
// ----------------------------------------------------------------------------
module dse_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [dse_pkg::IDX_BITS-1:0]   wr_index,
  input  logic [dse_pkg::CFG_BITS-1:0]   wr_data,
  output dse_pkg::cfg_t                  cfg
);
  import dse_pkg::*;

  logic                  filter_on;
  logic [SCORE_BITS:0]   ema_weight;
  logic [COUNT_BITS-1:0] hold_limit;
  logic [NEED_BITS-1:0]  reacquire_count;
  logic [SCORE_BITS-1:0] score_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_on       <= 1'b1;
      ema_weight      <= (SCORE_BITS+1)'(22938);
      hold_limit      <= COUNT_BITS'(5);
      reacquire_count <= NEED_BITS'(2);
      score_floor     <= SCORE_BITS'(32768);
    end else if (wr_en) begin
      case (wr_index)
        REG_FILTER_ON:   filter_on       <= wr_data[0];
        REG_EMA_WEIGHT:  ema_weight      <= wr_data[SCORE_BITS:0];
        REG_HOLD_LIMIT:  hold_limit      <= wr_data[COUNT_BITS-1:0];
        REG_REACQUIRE:   reacquire_count <= wr_data[NEED_BITS-1:0];
        REG_SCORE_FLOOR: score_floor     <= wr_data[SCORE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.filter_on  = filter_on;
    cfg.hold_limit = hold_limit;
    if (ema_weight < WEIGHT_MIN)  cfg.weight = WEIGHT_MIN;
    else if (ema_weight > ONE_Q)  cfg.weight = ONE_Q;
    else                          cfg.weight = ema_weight;
    if (score_floor < FLOOR_MIN)      cfg.floor = FLOOR_MIN;
    else if (score_floor > FLOOR_MAX) cfg.floor = FLOOR_MAX;
    else                              cfg.floor = score_floor;
    cfg.need = (reacquire_count < NEED_MIN) ? NEED_MIN : reacquire_count;
  end

endmodule

[rtl/dse_track.sv]
// ----------------------------------------------------------------------------
// dse_track
// Track state and the single-pass update: acceptance, kind reacquire,
// EMA blend, miss hold with decay, and pass-through.
// ----------------------------------------------------------------------------
module dse_track (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  dse_pkg::item_t   item,
  input  dse_pkg::cfg_t    cfg,
  output dse_pkg::result_t res
);
  import dse_pkg::*;

  logic                  have_track,    have_track_next;
  logic [KIND_BITS-1:0]  track_kind,    track_kind_next;
  logic [SCORE_BITS-1:0] track_score,   track_score_next;
  logic [COORD_BITS-1:0] track_x,       track_x_next;
  logic [COORD_BITS-1:0] track_y,       track_y_next;
  logic [SCORE_BITS-1:0] decayed_score, decayed_score_next;
  logic [KIND_BITS-1:0]  pending_kind,  pending_kind_next;
  logic [NEED_BITS-1:0]  pending_count, pending_count_next;
  logic [COUNT_BITS-1:0] stable_count,  stable_count_next;
  logic [COUNT_BITS-1:0] miss_count,    miss_count_next;

  logic                  accept;
  logic [SCORE_BITS-1:0] blend_s;
  logic [COORD_BITS-1:0] blend_x;
  logic [COORD_BITS-1:0] blend_y;
  logic [SCORE_BITS-1:0] decay_s;

  assign accept  = item.valid && (item.kind != KIND_NONE) && (item.score >= cfg.floor);
  assign blend_s = blend(track_score, item.score, cfg.weight);
  // coordinates blend in offset binary
  assign blend_x = blend(track_x ^ COORD_SIGN, item.x ^ COORD_SIGN, cfg.weight) ^ COORD_SIGN;
  assign blend_y = blend(track_y ^ COORD_SIGN, item.y ^ COORD_SIGN, cfg.weight) ^ COORD_SIGN;
  assign decay_s = decay((miss_count == '0) ? track_score : decayed_score);

  always_comb begin
    have_track_next    = have_track;
    track_kind_next    = track_kind;
    track_score_next   = track_score;
    track_x_next       = track_x;
    track_y_next       = track_y;
    decayed_score_next = decayed_score;
    pending_kind_next  = pending_kind;
    pending_count_next = pending_count;
    stable_count_next  = stable_count;
    miss_count_next    = miss_count;

    res.valid      = item.valid;
    res.kind       = item.kind;
    res.score      = item.score;
    res.x          = item.x;
    res.y          = item.y;
    res.stable     = 1'b0;
    res.held       = 1'b0;
    res.run_length = '0;

    if (!cfg.filter_on) begin
      res.stable     = item.valid;
      res.run_length = {{(COUNT_BITS-1){1'b0}}, item.valid};
    end else if (!accept) begin
      pending_kind_next  = KIND_NONE;
      pending_count_next = '0;
      if (have_track && (miss_count < cfg.hold_limit)) begin
        decayed_score_next = decay_s;
        miss_count_next    = miss_count + COUNT_BITS'(1);
        res.valid      = 1'b1;
        res.kind       = track_kind;
        res.score      = decay_s;
        res.x          = track_x;
        res.y          = track_y;
        res.stable     = 1'b1;
        res.held       = 1'b1;
        res.run_length = stable_count;
      end else begin
        have_track_next    = 1'b0;
        track_kind_next    = KIND_NONE;
        track_score_next   = '0;
        track_x_next       = '0;
        track_y_next       = '0;
        decayed_score_next = '0;
        stable_count_next  = '0;
        miss_count_next    = '0;
      end
    end else if (!have_track) begin
      // first accept starts the track from the raw detection
      miss_count_next    = '0;
      have_track_next    = 1'b1;
      stable_count_next  = COUNT_BITS'(1);
      pending_kind_next  = KIND_NONE;
      pending_count_next = '0;
      track_kind_next    = item.kind;
      track_score_next   = item.score;
      track_x_next       = item.x;
      track_y_next       = item.y;
      res.valid          = 1'b1;
      res.run_length     = COUNT_BITS'(1);
    end else begin
      miss_count_next = '0;
      if (item.kind == track_kind) begin
        if (stable_count < COUNT_MAX) stable_count_next = stable_count + COUNT_BITS'(1);
        pending_kind_next  = KIND_NONE;
        pending_count_next = '0;
      end else begin
        if (pending_kind == item.kind) begin
          pending_count_next = (pending_count < PENDING_MAX) ?
                               pending_count + NEED_BITS'(1) : pending_count;
        end else begin
          pending_kind_next  = item.kind;
          pending_count_next = NEED_BITS'(1);
        end
        if (pending_count_next >= cfg.need) begin
          track_kind_next    = item.kind;
          stable_count_next  = {{(COUNT_BITS-NEED_BITS){1'b0}}, pending_count_next};
          pending_kind_next  = KIND_NONE;
          pending_count_next = '0;
        end
      end
      track_score_next = blend_s;
      track_x_next     = blend_x;
      track_y_next     = blend_y;
      res.valid        = 1'b1;
      res.kind         = track_kind_next;
      res.score        = blend_s;
      res.x            = blend_x;
      res.y            = blend_y;
      res.stable       = stable_count_next >= {{(COUNT_BITS-NEED_BITS){1'b0}}, cfg.need};
      res.run_length   = stable_count_next;
    end

    res.is_junction = junction(res.kind);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_track    <= 1'b0;
      track_kind    <= KIND_NONE;
      track_score   <= '0;
      track_x       <= '0;
      track_y       <= '0;
      decayed_score <= '0;
      pending_kind  <= KIND_NONE;
      pending_count <= '0;
      stable_count  <= '0;
      miss_count    <= '0;
    end else if (en) begin
      have_track    <= have_track_next;
      track_kind    <= track_kind_next;
      track_score   <= track_score_next;
      track_x       <= track_x_next;
      track_y       <= track_y_next;
      decayed_score <= decayed_score_next;
      pending_kind  <= pending_kind_next;
      pending_count <= pending_count_next;
      stable_count  <= stable_count_next;
      miss_count    <= miss_count_next;
    end
  end

endmodule

[rtl/detection_stabilizer_ema_hold_unit.sv]
// ----------------------------------------------------------------------------
// detection_stabilizer_ema_hold_unit
// Per-frame detection stabilizer: EMA smoothing, kind reacquire, miss hold.
//
//   channel  dir  handshake             payload
//   s_*      in   s_tvalid / s_tready   s_tdata, s_tuser (raw detection)
//   m_*      out  m_tvalid / m_tready   m_tdata, m_tuser (stable detection)
//   cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A transaction passes the input register, then the result register; one
// transaction per cycle while m_tready is high, set by the single-pass
// update between the two. Reset clears the track and loads register
// defaults. A stalled m_* side holds its result; the input register still
// advances when the result register is empty or taken. cfg_ready is high.
// ----------------------------------------------------------------------------
module detection_stabilizer_ema_hold_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [0] in_valid, [16:1] in_score, [32:17] in_x, [48:33] in_y, zero pad
  input  logic [dse_pkg::IN_TDATA_BITS-1:0]     s_tdata,
  // [2:0] in_kind, zero pad
  input  logic [dse_pkg::TUSER_BITS-1:0]        s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [0] out_valid, [16:1] out_score, [32:17] out_x, [48:33] out_y,
  // [49] out_stable, [50] out_held, [58:51] run_length, [59] is_junction
  output logic [dse_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
  // [2:0] out_kind, zero pad
  output logic [dse_pkg::TUSER_BITS-1:0]        m_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dse_pkg::IDX_BITS-1:0]          cfg_index,
  input  logic [dse_pkg::CFG_BITS-1:0]          cfg_data
);
  import dse_pkg::*;

  item_t   in_item;
  item_t   stage;
  logic    stage_valid;
  logic    advance;
  cfg_t    cfg;
  result_t step_res;
  result_t out_res;

  assign cfg_ready = 1'b1;

  assign in_item.valid = s_tdata[0];
  assign in_item.score = s_tdata[SCORE_BITS:1];
  assign in_item.x     = s_tdata[SCORE_BITS+COORD_BITS:SCORE_BITS+1];
  assign in_item.y     = s_tdata[SCORE_BITS+2*COORD_BITS:SCORE_BITS+COORD_BITS+1];
  assign in_item.kind  = s_tuser[KIND_BITS-1:0];

  assign advance  = stage_valid && (!m_tvalid || m_tready);
  assign s_tready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage <= in_item;
    end
  end

  dse_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dse_track u_track (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (stage),
    .cfg  (cfg),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = OUT_TDATA_BITS'({out_res.is_junction, out_res.run_length, out_res.held,
                                    out_res.stable, out_res.y, out_res.x, out_res.score,
                                    out_res.valid});
  assign m_tuser = TUSER_BITS'(out_res.kind);

endmodule
